// ===== sv/tmdf_pkg.sv =====
// ----------------------------------------------------------------------------
// tmdf_pkg
// Shared widths and types for the trimmed-mean difference filter.
// ----------------------------------------------------------------------------
package tmdf_pkg;

    localparam int SAMPLE_W = 16;           // input sample width
    localparam int DIFF_W   = 17;           // sample difference width
    localparam int RATE_W   = 17;           // filtered rate width
    localparam int S_TDATA_W = 16;          // input word, whole bytes
    localparam int M_TDATA_W = 24;          // output word, whole bytes

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic signed [DIFF_W-1:0]   diff_t;
    typedef logic signed [RATE_W-1:0]   rate_t;

endpackage

// ===== sv/tmdf_ram.sv =====
// ----------------------------------------------------------------------------
// tmdf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module tmdf_ram #(
    parameter int WIDTH = 17,
    parameter int DEPTH = 20
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== sv/tmdf_div.sv =====
// ----------------------------------------------------------------------------
// tmdf_div
// Unsigned division by a constant through reciprocal multiplication,
// with registered quotient and done.
// ----------------------------------------------------------------------------
module tmdf_div #(
    parameter int NW      = 23,     // dividend / quotient width
    parameter int DIVISOR = 18
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          start,
    input  logic [NW-1:0] dividend,
    output logic          done,
    output logic [NW-1:0] quotient
);

    // q = (n * ceil(2^KS / d)) >> KS is exact for every n below 2^NW
    localparam int KS = NW + $clog2(DIVISOR);
    localparam int MW = NW + 1;
    localparam int PW = NW + MW;
    localparam logic [MW-1:0] RECIP =
        MW'(((64'd1 << KS) + 64'(DIVISOR - 1)) / 64'(DIVISOR));

    logic [PW-1:0] prod;
    logic [NW-1:0] quo_reg, quo_next;
    logic          done_reg, done_next;

    assign prod = PW'(dividend) * PW'(RECIP);

    always_comb begin
        quo_next  = start ? NW'(prod >> KS) : quo_reg;
        done_next = start;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            done_reg <= 1'b0;
        end else begin
            done_reg <= done_next;
        end
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== sv/trimmed_mean_difference_filter_core.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_difference_filter_core
// Difference of successive samples, windowed olympic (trimmed) mean.
// ----------------------------------------------------------------------------
//  channel | dir | handshake          | payload
//  s_      | in  | s_tvalid/s_tready  | s_tdata[15:0] sample
//  m_      | out | m_tvalid/m_tready  | m_tdata[16:0] filtered_rate
//
//  Each word passes through a write, a scan of every window entry through the
//  single read port of the window RAM, a trim step, a reciprocal multiply
//  and an output step.
//  Reset marks every window entry invalid (reads as zero).
//  A new word is taken while the last result still waits on m_tready;
//  a result that finds the output register full holds until it drains.
// ----------------------------------------------------------------------------
module trimmed_mean_difference_filter_core #(
    parameter int WINDOW = 20
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    input  logic [tmdf_pkg::S_TDATA_W-1:0] s_tdata,   // [15:0] sample
    output logic                           m_tvalid,
    input  logic                           m_tready,
    output logic [tmdf_pkg::M_TDATA_W-1:0] m_tdata    // [16:0] filtered_rate
);

    import tmdf_pkg::*;

    localparam int AW      = $clog2(WINDOW);
    localparam int SW      = DIFF_W + AW;           // window sum
    localparam int NW      = SW + 1;                // trimmed numerator
    localparam int DIVISOR = WINDOW - 2;
    localparam int HALF    = (WINDOW - 2) / 2;

    typedef enum logic [2:0] {
        ST_IDLE, ST_SCAN, ST_TRIM, ST_DIV, ST_OUT
    } state_t;

    state_t                state_reg, state_next;
    logic [AW-1:0]         slot_reg, slot_next;
    sample_t               prev_reg, prev_next;
    logic [WINDOW-1:0]     valid_reg, valid_next;
    logic [AW:0]           cnt_reg, cnt_next;
    logic                  vq_reg, vq_next;
    logic signed [SW-1:0]  sum_reg, sum_next;
    diff_t                 max_reg, max_next;
    diff_t                 min_reg, min_next;
    logic                  neg_reg, neg_next;
    rate_t                 res_reg, res_next;
    logic                  m_valid_reg, m_valid_next;
    rate_t                 m_data_reg, m_data_next;

    logic                  accept;
    sample_t               s_sample;
    diff_t                 s_diff;
    logic [DIFF_W-1:0]     ram_rdata;
    diff_t                 entry;
    logic signed [NW-1:0]  num;
    logic [NW-1:0]         mag;
    logic                  div_start;
    logic                  div_done;
    logic [NW-1:0]         div_quo;
    logic [RATE_W-1:0]     quo_low;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign s_sample = s_tdata[SAMPLE_W-1:0];
    assign s_diff   = {s_sample[SAMPLE_W-1], s_sample} - {prev_reg[SAMPLE_W-1], prev_reg};

    tmdf_ram #(
        .WIDTH (DIFF_W),
        .DEPTH (WINDOW)
    ) u_window (
        .aclk  (aclk),
        .we    (accept),
        .waddr (slot_reg),
        .wdata (s_diff),
        .raddr (cnt_reg[AW-1:0]),
        .rdata (ram_rdata)
    );

    // never-written entries are masked to zero by their valid bit
    assign entry = vq_reg ? diff_t'(ram_rdata) : '0;

    assign num = NW'(sum_reg) - NW'(max_reg) - NW'(min_reg) + NW'(HALF);
    // floor for negatives: -(ceil(|n| / d))
    assign mag = num[NW-1] ? (NW'(DIVISOR - 1) - num) : num;
    assign div_start = (state_reg == ST_TRIM);

    tmdf_div #(
        .NW      (NW),
        .DIVISOR (DIVISOR)
    ) u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (mag),
        .done     (div_done),
        .quotient (div_quo)
    );

    assign quo_low = div_quo[RATE_W-1:0];

    always_comb begin
        state_next   = state_reg;
        slot_next    = slot_reg;
        prev_next    = prev_reg;
        valid_next   = valid_reg;
        cnt_next     = cnt_reg;
        vq_next      = valid_reg[cnt_reg[AW-1:0]];
        sum_next     = sum_reg;
        max_next     = max_reg;
        min_next     = min_reg;
        neg_next     = neg_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg && !m_tready;
        m_data_next  = m_data_reg;

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    valid_next[slot_reg] = 1'b1;
                    slot_next  = (slot_reg == AW'(WINDOW - 1)) ? '0 : slot_reg + 1'b1;
                    prev_next  = s_sample;
                    cnt_next   = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                // read entry cnt, fold in entry cnt-1 from the previous read
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == (AW+1)'(1)) begin
                    sum_next = SW'(entry);
                    max_next = entry;
                    min_next = entry;
                end else if (cnt_reg != '0) begin
                    sum_next = sum_reg + SW'(entry);
                    if (entry > max_reg) begin
                        max_next = entry;
                    end
                    if (entry < min_reg) begin
                        min_next = entry;
                    end
                end
                if (cnt_reg == (AW+1)'(WINDOW)) begin
                    state_next = ST_TRIM;
                end
            end
            ST_TRIM: begin
                neg_next   = num[NW-1];
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    res_next   = neg_reg ? rate_t'(-quo_low) : rate_t'(quo_low);
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_tready) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            slot_reg    <= '0;
            prev_reg    <= '0;
            valid_reg   <= '0;
            cnt_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            slot_reg    <= slot_next;
            prev_reg    <= prev_next;
            valid_reg   <= valid_next;
            cnt_reg     <= cnt_next;
            m_valid_reg <= m_valid_next;
        end
        vq_reg     <= vq_next;
        sum_reg    <= sum_next;
        max_reg    <= max_next;
        min_reg    <= min_next;
        neg_reg    <= neg_next;
        res_reg    <= res_next;
        m_data_reg <= m_data_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{(M_TDATA_W-RATE_W){1'b0}}, m_data_reg};

endmodule

// ===== sv/tmdf_checker.sv =====
// ----------------------------------------------------------------------------
// tmdf_checker
// Port-level checks for the trimmed-mean difference filter.
// ----------------------------------------------------------------------------
module tmdf_checker (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [tmdf_pkg::M_TDATA_W-1:0] m_tdata
);

    import tmdf_pkg::*;

    // held result word stays put
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result word changed while stalled");

    // a word just taken keeps the input closed and cannot finish at once
    a_busy_after_take: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready && !$rose(m_tvalid))
        else $error("input reopened or result appeared right after a take");

    // padding is zero and the mean never reaches -65536
    a_out_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[M_TDATA_W-1:RATE_W] == '0
                     && m_tdata[RATE_W-1:0] != 17'h10000)
        else $error("result word out of range");

    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid && s_tready)
        else $error("not idle after reset");

endmodule

bind trimmed_mean_difference_filter_core tmdf_checker u_tmdf_checker (.*);

// ===== tb/sv/trimmed_mean_difference_filter_core_tb.sv =====
// ----------------------------------------------------------------------------
// trimmed_mean_difference_filter_core_tb
// Drives signed samples into the filter and checks each filtered rate against
// an in-bench model of the difference window and its trimmed, rounded mean.
// A short table covers reset, extremes, ties and negative rounding, then
// random walks, full-range values and extreme swings follow, with random
// stalls on both channels.
// ----------------------------------------------------------------------------
module trimmed_mean_difference_filter_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import tmdf_pkg::*;

    localparam int WIN        = 20;
    localparam int KEPT       = WIN - 2;
    localparam int RAND_ITEMS = 1000;
    localparam int DIR_N      = 24;

    typedef struct {
        int  sample;
        bit  fixed;     // expected rate typed in below
        int  rate;
    } stim_row_t;

    // reset, extremes, ties (constant steps), odd negative steps for rounding
    stim_row_t dir_table [DIR_N] = '{
        '{0,      1'b1, 0},
        '{32767,  1'b1, 0},
        '{-32768, 1'b1, 0},
        '{32767,  1'b0, 0},
        '{-32768, 1'b0, 0},
        '{21845,  1'b0, 0},
        '{-21846, 1'b0, 0},
        '{1,      1'b0, 0},
        '{-1,     1'b0, 0},
        '{-1000,  1'b0, 0},
        '{-1007,  1'b0, 0},
        '{-1014,  1'b0, 0},
        '{-1021,  1'b0, 0},
        '{-1028,  1'b0, 0},
        '{-1035,  1'b0, 0},
        '{-1042,  1'b0, 0},
        '{-1029,  1'b0, 0},
        '{-1016,  1'b0, 0},
        '{-1003,  1'b0, 0},
        '{-990,   1'b0, 0},
        '{-990,   1'b0, 0},
        '{-990,   1'b0, 0},
        '{32767,  1'b0, 0},
        '{32767,  1'b0, 0}
    };

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata;      // [15:0] sample
    logic                 m_tvalid;
    logic                 m_tready;
    logic [M_TDATA_W-1:0] m_tdata;      // [16:0] filtered_rate

    // model state
    int      diff_hist [WIN];
    int      hist_slot;
    sample_t last_sample;

    rate_t   rate_expect_q [$];
    int      fail_count;
    bit      quiet_stretch;
    rate_t   got_rate;
    rate_t   want_rate;

    trimmed_mean_difference_filter_core #(
        .WINDOW (WIN)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // push one difference, drop one max and one min, floor-rounded mean
    function automatic rate_t trimmed_rate_of(input sample_t s);
        longint acc;
        longint q;
        int     hi;
        int     lo;
        diff_hist[hist_slot] = int'(s) - int'(last_sample);
        hist_slot = (hist_slot + 1) % WIN;
        last_sample = s;
        acc = 0;
        hi = diff_hist[0];
        lo = diff_hist[0];
        for (int k = 0; k < WIN; k++) begin
            if (diff_hist[k] > hi) hi = diff_hist[k];
            if (diff_hist[k] < lo) lo = diff_hist[k];
            acc += diff_hist[k];
        end
        acc = acc - hi - lo + KEPT / 2;
        q = acc / KEPT;
        if ((acc % KEPT) != 0 && acc < 0) q = q - 1;
        return rate_t'(q);
    endfunction

    task automatic report_mismatch(input string what, input rate_t got, input rate_t want);
        $display("%0t: %s: got %0d, expected %0d", $realtime, what, got, want);
        fail_count++;
    endtask

    // present one word, wait for the handshake, record its expected rate
    task automatic send_sample(input sample_t s, input bit fixed, input rate_t typed_rate);
        rate_t predicted;
        s_tvalid <= 1'b1;
        s_tdata  <= s;
        do @(posedge aclk); while (!s_tready);
        predicted = trimmed_rate_of(s);
        rate_expect_q.push_back(fixed ? typed_rate : predicted);
        // occasional gap before the next word, landing on any phase of the scan
        if (!quiet_stretch && $urandom_range(0, 99) < 6) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 60)) @(posedge aclk);
        end
    endtask

    function automatic sample_t clamp_sample(input int v);
        if (v > 32767) return sample_t'(32767);
        if (v < -32768) return sample_t'(-32768);
        return sample_t'(v);
    endfunction

    // result side: check each word, then pick next cycle's ready
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            got_rate = rate_t'(m_tdata[RATE_W-1:0]);
            if (rate_expect_q.size() == 0) begin
                report_mismatch("unexpected result word", got_rate, '0);
            end else begin
                want_rate = rate_expect_q.pop_front();
                if (got_rate !== want_rate)
                    report_mismatch("filtered_rate mismatch", got_rate, want_rate);
            end
        end
        m_tready <= (!quiet_stretch && $urandom_range(0, 99) < 6) ? 1'b0 : 1'b1;
    end

    initial begin
        sample_t prev_sent;
        int      pick;
        sample_t nxt;
        int      step;

        aclk          = 1'b0;
        aresetn       <= 1'b0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        m_tready      <= 1'b0;
        fail_count    = 0;
        quiet_stretch = 1'b0;
        for (int k = 0; k < WIN; k++) diff_hist[k] = 0;
        hist_slot   = 0;
        last_sample = '0;
        prev_sent   = '0;
        step        = 0;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (dir_table[i]) begin
            send_sample(sample_t'(dir_table[i].sample), dir_table[i].fixed,
                        rate_t'(dir_table[i].rate));
            prev_sent = sample_t'(dir_table[i].sample);
        end

        for (int n = 0; n < RAND_ITEMS; n++) begin
            quiet_stretch = (n >= 500 && n < 700);
            pick = $urandom_range(0, 99);
            if (pick < 40) begin
                // random walk
                nxt = clamp_sample(int'(prev_sent) + int'($urandom_range(0, 600)) - 300);
            end else if (pick < 70) begin
                nxt = sample_t'($urandom);
            end else if (pick < 85) begin
                // full-scale swings
                nxt = $urandom_range(0, 1) ? sample_t'(32767 - $urandom_range(0, 3))
                                           : sample_t'(-32768 + $urandom_range(0, 3));
            end else begin
                // repeated steps give tied window entries
                if ($urandom_range(0, 3) == 0) step = int'($urandom_range(0, 40)) - 20;
                nxt = clamp_sample(int'(prev_sent) + step);
            end
            send_sample(nxt, 1'b0, '0);
            prev_sent = nxt;
        end
        quiet_stretch = 1'b0;
        s_tvalid <= 1'b0;

        while (rate_expect_q.size() != 0) @(posedge aclk);
        repeat (64) @(posedge aclk);

        if (fail_count == 0) begin
            $display("trimmed_mean_difference_filter_core test passed");
        end else begin
            $display("trimmed_mean_difference_filter_core test failed");
        end
        $finish;
    end

    initial begin
        #5ms;
        $display("timeout waiting for results");
        $display("trimmed_mean_difference_filter_core test failed");
        $finish;
    end

endmodule
